FILE: rtl/aes_pkg.sv
// Shared types, S-box and round helpers for the AES-128 block encryptor.
package aes_pkg;
	localparam int unsigned ROUNDS = 10;
	localparam int unsigned KEY_WORDS = 4 * (ROUNDS + 1);
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW = 2'd1;

	typedef logic [127:0] blk_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYX,
		ST_RUN,
		ST_DONE
	} state_t;

	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] tab [256];
		tab = '{
			8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
			8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
			8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
			8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
			8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
			8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
			8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
			8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
			8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
			8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
			8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
			8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
			8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
			8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
			8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
			8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return tab[v];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] c;
		case (r)
			4'd1: c = 8'h01;
			4'd2: c = 8'h02;
			4'd3: c = 8'h04;
			4'd4: c = 8'h08;
			4'd5: c = 8'h10;
			4'd6: c = 8'h20;
			4'd7: c = 8'h40;
			4'd8: c = 8'h80;
			4'd9: c = 8'h1b;
			4'd10: c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction
endpackage

FILE: rtl/aes_lane.sv
// One column lane: SubBytes of the shifted column, optional MixColumns, key add.
module aes_lane import aes_pkg::*; (
	input  logic [31:0] col,
	input  logic [31:0] rkey,
	input  logic        mix,
	output logic [31:0] res
);
	logic [7:0] a, b, d, e, x;
	logic [31:0] m;
	always_comb begin
		a = sbox(col[31:24]);
		b = sbox(col[23:16]);
		d = sbox(col[15:8]);
		e = sbox(col[7:0]);
		x = a ^ b ^ d ^ e;
		m = {a ^ x ^ xtime(a ^ b), b ^ x ^ xtime(b ^ d),
			d ^ x ^ xtime(d ^ e), e ^ x ^ xtime(e ^ a)};
		res = (mix ? m : {a, b, d, e}) ^ rkey;
	end
endmodule

FILE: rtl/aes_round.sv
// Round unit: ShiftRows routing into four column lanes, merged into the new state.
module aes_round import aes_pkg::*; (
	input  blk_t   state,
	input  blk_t   rkey,
	input  logic   mix,
	output blk_t   next
);
	function automatic logic [7:0] sb(input blk_t s, input int idx);
		return s[127 - 8*idx -: 8];
	endfunction
	for (genvar c = 0; c < 4; c++) begin : g_lane
		logic [31:0] col;
		assign col = {sb(state, 4*c), sb(state, 4*((c+1)%4)+1),
			sb(state, 4*((c+2)%4)+2), sb(state, 4*((c+3)%4)+3)};
		aes_lane u_lane (
			.col(col),
			.rkey(rkey[127-32*c -: 32]),
			.mix(mix),
			.res(next[127-32*c -: 32])
		);
	end
endmodule

FILE: rtl/aes128_block_encrypt.sv
// Top level of the AES-128 block encryptor.
// An item is accepted only while the block is idle; the initial key add is done as it is
// taken, and the ten rounds then run one per cycle on a single shared round unit of four
// column lanes. The result waits in the state register until taken, and the next item can
// be accepted in the following cycle. After a key register write the 44 round-key words
// are rebuilt one 4-word round key per cycle in the key memory before the next item is
// taken.
module aes128_block_encrypt import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // plain_low, plain_high
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // cipher_low, cipher_high
);
	state_t st_q, st_nx;
	logic [127:0] key_q;
	blk_t rk_mem [ROUNDS+1];
	blk_t rk_rd_q, st_blk_q, kx_q, rnd_out, kx_nx;
	logic [3:0] rnd_q;
	logic [31:0] w0, w1, w2, w3, tw;
	logic acc;

	assign acc = s_tvalid && s_tready;

	always_comb begin
		tw = {sbox(kx_q[23:16]), sbox(kx_q[15:8]), sbox(kx_q[7:0]), sbox(kx_q[31:24])}
			^ {rcon(rnd_q + 4'd1), 24'h0};
		w0 = kx_q[127:96] ^ tw;
		w1 = kx_q[95:64] ^ w0;
		w2 = kx_q[63:32] ^ w1;
		w3 = kx_q[31:0] ^ w2;
		kx_nx = {w0, w1, w2, w3};
	end

	aes_round u_round (
		.state(st_blk_q),
		.rkey(rk_rd_q),
		.mix(rnd_q != 4'(ROUNDS)),
		.next(rnd_out)
	);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: if (acc) st_nx = ST_RUN;
			ST_KEYX: if (rnd_q == 4'(ROUNDS - 1)) st_nx = ST_IDLE;
			ST_RUN:  if (rnd_q == 4'(ROUNDS)) st_nx = ST_DONE;
			ST_DONE: if (m_tready) st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
		if (cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW))
			st_nx = ST_KEYX;
	end

	always_comb begin
		s_tready = (st_q == ST_IDLE) && !cfg_we;
		m_tvalid = (st_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rnd_q <= '0;
			key_q <= '0;
		end else begin
			st_q <= st_nx;
			if (cfg_we && cfg_index == REG_KEY_HIGH) key_q[127:64] <= cfg_data;
			if (cfg_we && cfg_index == REG_KEY_LOW) key_q[63:0] <= cfg_data;
			if (st_nx == ST_KEYX && st_q != ST_KEYX) rnd_q <= '0;
			else if (cfg_we) rnd_q <= '0;
			else if (st_q == ST_KEYX) rnd_q <= rnd_q + 4'd1;
			else if (acc) rnd_q <= 4'd1;
			else if (st_q == ST_RUN) rnd_q <= rnd_q + 4'd1;
		end
	end

	// key expansion, round-key memory and its read register, and the state register
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			kx_q <= {cfg_index == REG_KEY_HIGH ? cfg_data : key_q[127:64],
				cfg_index == REG_KEY_LOW ? cfg_data : key_q[63:0]};
			rk_mem[0] <= {cfg_index == REG_KEY_HIGH ? cfg_data : key_q[127:64],
				cfg_index == REG_KEY_LOW ? cfg_data : key_q[63:0]};
		end else if (st_q == ST_KEYX) begin
			kx_q <= kx_nx;
			rk_mem[rnd_q + 4'd1] <= kx_nx;
		end
		if (acc) rk_rd_q <= rk_mem[1];
		else rk_rd_q <= rk_mem[(rnd_q >= 4'(ROUNDS)) ? 4'(ROUNDS) : rnd_q + 4'd1];
		if (acc) st_blk_q <= {s_tdata[63:0], s_tdata[127:64]} ^ rk_mem[0];
		else if (st_q == ST_RUN) st_blk_q <= rnd_out;
	end

	assign m_tdata = {st_blk_q[63:0], st_blk_q[127:64]};
endmodule

FILE: rtl/aes128_block_encrypt_chk.sv
// Port-level checker for the AES-128 block encryptor, bound to the top level.
module aes128_block_encrypt_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [127:0] m_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid) else $error("accept not followed by work");
endmodule

bind aes128_block_encrypt aes128_block_encrypt_chk u_chk (.*);

FILE: tb/aes128_block_encrypt_test.sv
// Self-checking testbench for aes128_block_encrypt: directed and random keys and blocks against a predictor.
module aes128_block_encrypt_test import aes_pkg::*;;

	localparam int WATCHDOG_LIMIT = 3000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [127:0] m_tdata;

	aes128_block_encrypt DUT (.*);

	always #5 clk = ~clk;

	logic [7:0]   sub_lut [256];
	logic [31:0]  key_sched [KEY_WORDS];
	logic [63:0]  key_hi_q = '0;
	logic [63:0]  key_lo_q = '0;
	logic [127:0] plain_q [$];
	logic [127:0] cipher_q [$];
	int           errors = 0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           quiet_cycles = 0;
	bit           calm = 1'b0;
	bit           hold_send = 1'b0;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
		end
		return p;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic void build_sub_lut();
		logic [7:0] inv;
		for (int v = 0; v < 256; v++) begin
			inv = 8'h01;
			for (int k = 0; k < 254; k++) inv = gf_mul(inv, v[7:0]);
			if (v == 0) inv = 8'h00;
			sub_lut[v] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
				^ rotl8(inv, 4) ^ 8'h63;
		end
	endfunction

	function automatic void build_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		key_sched[0] = key_hi_q[63:32];
		key_sched[1] = key_hi_q[31:0];
		key_sched[2] = key_lo_q[63:32];
		key_sched[3] = key_lo_q[31:0];
		for (int i = 4; i < KEY_WORDS; i++) begin
			t = key_sched[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]};
				t[31:24] ^= rc;
				rc = rc[7] ? ({rc[6:0], 1'b0} ^ 8'h1b) : {rc[6:0], 1'b0};
			end
			key_sched[i] = key_sched[i-4] ^ t;
		end
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] v);
		return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
	endfunction

	// tdata form both ways: high field in [63:0], low field in [127:64]
	function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
		logic [7:0]  st [16];
		logic [7:0]  tmp [16];
		logic [7:0]  a, b, d, e, x;
		logic [31:0] w;
		logic [127:0] res;
		for (int i = 0; i < 8; i++) begin
			st[i]   = blk[63 - 8*i -: 8];
			st[8+i] = blk[127 - 8*i -: 8];
		end
		for (int r = 0; r <= 10; r++) begin
			if (r > 0) begin
				for (int c = 0; c < 4; c++)
					for (int k = 0; k < 4; k++)
						tmp[4*c+k] = sub_lut[st[4*((c+k)%4)+k]];
				st = tmp;
				if (r < 10) begin
					for (int c = 0; c < 4; c++) begin
						a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
						x = a ^ b ^ d ^ e;
						st[4*c]   = a ^ x ^ dbl(a ^ b);
						st[4*c+1] = b ^ x ^ dbl(b ^ d);
						st[4*c+2] = d ^ x ^ dbl(d ^ e);
						st[4*c+3] = e ^ x ^ dbl(e ^ a);
					end
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = key_sched[4*r+c];
				for (int k = 0; k < 4; k++) st[4*c+k] ^= w[31 - 8*k -: 8];
			end
		end
		for (int i = 0; i < 8; i++) begin
			res[63 - 8*i -: 8]  = st[i];
			res[127 - 8*i -: 8] = st[8+i];
		end
		return res;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) cipher_q.push_back(encrypt_block(s_tdata));
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (plain_q.size() > 0 && !hold_send) begin
				s_tdata <= plain_q.pop_front();
				s_tvalid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 12);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			m_tready <= 1'b1;
		end else begin
			if (m_tvalid && m_tready) begin
				if (cipher_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected item: %h", m_tdata);
				end else begin
					want = cipher_q.pop_front();
					if (m_tdata[63:0] !== want[63:0] || m_tdata[127:64] !== want[127:64]) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: cipher_high exp %h got %h, cipher_low exp %h got %h",
								want[63:0], m_tdata[63:0], want[127:64], m_tdata[127:64]);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("aes128_block_encrypt verification failed");
			$finish;
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (plain_q.size() > 0 || s_tvalid || cipher_q.size() > 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_KEY_HIGH) key_hi_q = val;
		else if (idx == REG_KEY_LOW) key_lo_q = val;
		build_schedule();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) plain_q.push_back({rand64(), rand64()});
	endtask

	initial begin
		build_sub_lut();
		build_schedule();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// standard vector key
		write_reg(REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		plain_q.push_back({64'h8899aabbccddeeff, 64'h0011223344556677});
		plain_q.push_back('0);
		plain_q.push_back('1);
		plain_q.push_back({64'h0, 64'hffffffffffffffff});
		plain_q.push_back({64'hffffffffffffffff, 64'h0});
		plain_q.push_back({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
		plain_q.push_back({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
		plain_q.push_back({64'h0000000000000001, 64'h8000000000000000});

		write_reg(REG_KEY_HIGH, '0);
		write_reg(REG_KEY_LOW, '0);
		plain_q.push_back('0);
		plain_q.push_back('1);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		plain_q.push_back('0);
		plain_q.push_back('1);
		// partial update, then writes to unused indexes that must be ignored
		write_reg(REG_KEY_LOW, 64'h0123456789abcdef);
		plain_q.push_back({64'h0123456789abcdef, 64'hfedcba9876543210});
		write_reg(2'd2, 64'hdeadbeefdeadbeef);
		write_reg(2'd3, '1);
		plain_q.push_back({64'h0123456789abcdef, 64'hfedcba9876543210});
		plain_q.push_back('0);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 3 == 2) begin
				write_reg($urandom_range(0, 1) ? REG_KEY_HIGH : REG_KEY_LOW, rand64());
			end else begin
				write_reg(REG_KEY_HIGH, rand64());
				write_reg(REG_KEY_LOW, rand64());
			end
			if (ph == 7) calm = 1'b1;
			random_items(60);
			if (ph == 3) begin
				do @(posedge clk); while (plain_q.size() > 30);
				hold_send = 1'b1;
				do @(negedge clk); while (s_tvalid || cipher_q.size() > 0);
				@(posedge clk);
				hold_send = 1'b0;
			end
			random_items(60);
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && cipher_q.size() == 0) begin
			$display("aes128_block_encrypt verification clean");
		end else begin
			$display("aes128_block_encrypt verification failed");
		end
		$finish;
	end
endmodule
